>>> hw/rtl/array_list_search_delete_assert.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef ARRAY_LIST_SEARCH_DELETE_ASSERT_SVH
`define ARRAY_LIST_SEARCH_DELETE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ALSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ALSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/alsd_pkg.sv
package alsd_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 6;
    localparam int CMD_W  = 3;
    localparam int ST_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_POP       = 3'd1,
        CMD_REMOVE_AT = 3'd2,
        CMD_FIND      = 3'd3,
        CMD_FIND_DEL  = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_BAD_POS   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  fill;
        logic              last;
    } t_result;

endpackage

>>> hw/rtl/alsd_ram.sv
module alsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/array_list_search_delete.sv
// Packed list of signed 32-bit words with search and delete.
// Input channel s_axis: tuser carries the command (append, remove last, remove at
// position, find all, find and remove all); tdata carries the value and position.
// Output channel m_axis: tuser carries the status, tdata index and fill, tlast
// marks the final word of a command. Every command gives at least one word, except
// unknown command codes, which are dropped.
// Append and remove last finish in the accepting cycle; the result word appears
// on the next cycle. Remove at position walks the tail, one entry per cycle.
// Find makes two passes over the store, one entry per cycle through the single
// read port of the word memory: a counting pass and a reporting pass, which
// pauses at each match and while the receiver stalls; a miss ends after the
// counting pass with a closing word. Find and remove compacts the store in the
// reporting pass with the memory's write port.
// s_axis_tready is high only while the block is idle and the output register is
// free or being emptied. A stalled receiver holds the output word and pauses the
// reporting pass. Reset clears the fill count and empties the output register;
// the word store itself is not cleared, since only filled positions are read.
`include "array_list_search_delete_assert.svh"

module array_list_search_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], position[37:32], zero pad
    input  logic [2:0]  s_axis_tuser,   // command[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // index[5:0], fill[12:6], zero pad
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast
);

    localparam int ADDR_W = alsd_pkg::ADDR_W;
    localparam int CNT_W  = alsd_pkg::CNT_W;
    localparam int VAL_W  = alsd_pkg::VAL_W;
    localparam int IDX_W  = alsd_pkg::IDX_W;

    alsd_pkg::t_state  r_state;
    alsd_pkg::t_state  n_state;
    alsd_pkg::t_cmd    r_cmd;
    alsd_pkg::t_cmd    in_cmd;
    alsd_pkg::t_result r_out;
    logic              r_out_valid;
    alsd_pkg::t_status r_fin_status;
    logic [CNT_W-1:0]  r_fin_fill;

    logic [VAL_W-1:0]  r_key;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_wr_idx;
    logic [ADDR_W-1:0] r_cmp_idx;
    logic              r_dv;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_emit_cnt;
    logic [CNT_W-1:0]  r_fill_after;

    logic [VAL_W-1:0]  in_value;
    logic [CNT_W-1:0]  in_pos;
    logic              accept;
    logic              out_free;
    logic              out_load;
    logic              list_empty;
    logic              list_full;
    logic              pos_bad;
    logic              scan_left;
    logic              scan_done;
    logic              match;
    logic              is_find;
    logic              emit_now;
    logic              drop;
    logic              keep_wr;
    logic              del_done;

    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [VAL_W-1:0]  rd_data;

    alsd_ram #(
        .WIDTH (VAL_W),
        .DEPTH (alsd_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign in_cmd     = alsd_pkg::t_cmd'(s_axis_tuser);
    assign in_value   = s_axis_tdata[31:0];
    assign in_pos     = CNT_W'(s_axis_tdata[37:32]);
    assign out_free   = !r_out_valid || m_axis_tready;
    assign list_empty = (r_count == '0);
    assign list_full  = (r_count >= CNT_W'(alsd_pkg::DEPTH));
    assign pos_bad    = (in_pos >= r_count);
    assign scan_left  = (r_rd_idx < r_count);
    assign scan_done  = !scan_left && !r_dv;
    assign match      = r_dv && (rd_data == r_key);
    assign is_find    = (r_cmd == alsd_pkg::CMD_FIND) || (r_cmd == alsd_pkg::CMD_FIND_DEL);
    assign del_done   = (r_state == alsd_pkg::S_SCAN) && scan_done
                     && (r_cmd == alsd_pkg::CMD_FIND_DEL);

    // load the output register: one-word answers at accept, matches, closing word
    assign out_load = emit_now
                   || ((r_state == alsd_pkg::S_FIN) && out_free)
                   || (accept && ((in_cmd == alsd_pkg::CMD_APPEND)
                                  || (in_cmd == alsd_pkg::CMD_POP)
                                  || ((in_cmd == alsd_pkg::CMD_REMOVE_AT)
                                      && (list_empty || pos_bad))
                                  || (((in_cmd == alsd_pkg::CMD_FIND)
                                       || (in_cmd == alsd_pkg::CMD_FIND_DEL))
                                      && list_empty)));

    assign s_axis_tready = (r_state == alsd_pkg::S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alsd_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        alsd_pkg::CMD_REMOVE_AT: begin
                            if (!list_empty && !pos_bad) begin
                                n_state = alsd_pkg::S_SCAN;
                            end
                        end
                        alsd_pkg::CMD_FIND, alsd_pkg::CMD_FIND_DEL: begin
                            if (!list_empty) begin
                                n_state = alsd_pkg::S_COUNT;
                            end
                        end
                        default: begin
                            n_state = alsd_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            alsd_pkg::S_COUNT: begin
                if (scan_done) begin
                    n_state = (r_hits == '0) ? alsd_pkg::S_FIN : alsd_pkg::S_SCAN;
                end
            end
            alsd_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = (r_cmd == alsd_pkg::CMD_REMOVE_AT) ? alsd_pkg::S_FIN
                                                                 : alsd_pkg::S_IDLE;
                end
            end
            alsd_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = alsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = alsd_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath controls
    always_comb begin
        rd_en    = 1'b0;
        emit_now = 1'b0;
        drop     = 1'b0;
        keep_wr  = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_wr_idx[ADDR_W-1:0];
        wr_data  = rd_data;
        unique case (r_state)
            alsd_pkg::S_IDLE: begin
                if (accept && (in_cmd == alsd_pkg::CMD_APPEND) && !list_full) begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[ADDR_W-1:0];
                    wr_data = in_value;
                end
            end
            alsd_pkg::S_COUNT: begin
                rd_en = scan_left;
            end
            alsd_pkg::S_SCAN: begin
                emit_now = is_find && match;
                drop     = ((r_cmd == alsd_pkg::CMD_FIND_DEL) && match)
                        || ((r_cmd == alsd_pkg::CMD_REMOVE_AT) && r_dv
                            && (CNT_W'(r_cmp_idx) == r_pos));
                keep_wr  = r_dv && !drop && (r_cmd != alsd_pkg::CMD_FIND);
                wr_en    = keep_wr;
                // hold reads while a match waits on the output register
                rd_en    = scan_left && (!is_find || (out_free && !emit_now));
            end
            alsd_pkg::S_FIN: begin
                rd_en = 1'b0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alsd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_dv        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= rd_en;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                alsd_pkg::S_IDLE: begin
                    if (accept) begin
                        unique case (in_cmd)
                            alsd_pkg::CMD_APPEND: begin
                                if (list_full) begin
                                    r_out <= '{alsd_pkg::ST_FULL, '0, r_count, 1'b1};
                                end else begin
                                    r_count <= r_count + CNT_W'(1);
                                    r_out   <= '{alsd_pkg::ST_OK, '0,
                                                 r_count + CNT_W'(1), 1'b1};
                                end
                            end
                            alsd_pkg::CMD_POP: begin
                                if (list_empty) begin
                                    r_out <= '{alsd_pkg::ST_EMPTY, '0, r_count, 1'b1};
                                end else begin
                                    r_count <= r_count - CNT_W'(1);
                                    r_out   <= '{alsd_pkg::ST_OK, '0,
                                                 r_count - CNT_W'(1), 1'b1};
                                end
                            end
                            alsd_pkg::CMD_REMOVE_AT: begin
                                if (list_empty) begin
                                    r_out <= '{alsd_pkg::ST_EMPTY, '0, r_count, 1'b1};
                                end else if (pos_bad) begin
                                    r_out <= '{alsd_pkg::ST_BAD_POS, '0, r_count, 1'b1};
                                end
                            end
                            alsd_pkg::CMD_FIND, alsd_pkg::CMD_FIND_DEL: begin
                                if (list_empty) begin
                                    r_out <= '{alsd_pkg::ST_EMPTY, '0, r_count, 1'b1};
                                end
                            end
                            default: begin
                                // unknown code: drop, no word
                                r_out <= r_out;
                            end
                        endcase
                    end
                end
                alsd_pkg::S_COUNT: begin
                    if (scan_done && (r_hits == '0)) begin
                        r_fin_status <= alsd_pkg::ST_NOT_FOUND;
                        r_fin_fill   <= r_count;
                    end
                end
                alsd_pkg::S_SCAN: begin
                    if (emit_now) begin
                        r_out <= '{alsd_pkg::ST_FOUND, IDX_W'(r_cmp_idx), r_fill_after,
                                   (r_emit_cnt + CNT_W'(1)) == r_hits};
                    end
                    if (scan_done) begin
                        unique case (r_cmd)
                            alsd_pkg::CMD_REMOVE_AT: begin
                                r_count      <= r_count - CNT_W'(1);
                                r_fin_status <= alsd_pkg::ST_OK;
                                r_fin_fill   <= r_count - CNT_W'(1);
                            end
                            alsd_pkg::CMD_FIND_DEL: begin
                                r_count <= r_count - r_hits;
                            end
                            default: begin
                                r_count <= r_count;
                            end
                        endcase
                    end
                end
                alsd_pkg::S_FIN: begin
                    if (out_free) begin
                        r_out <= '{r_fin_status, '0, r_fin_fill, 1'b1};
                    end
                end
                default: begin
                    r_out <= r_out;
                end
            endcase
        end
    end

    // Scan pointers and counters
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= in_cmd;
            r_key      <= in_value;
            r_pos      <= in_pos;
            r_hits     <= '0;
            // remove at position starts its walk at the removed slot
            r_rd_idx   <= (in_cmd == alsd_pkg::CMD_REMOVE_AT) ? in_pos : '0;
            r_wr_idx   <= in_pos;
        end else begin
            if (rd_en) begin
                r_rd_idx  <= r_rd_idx + CNT_W'(1);
                r_cmp_idx <= r_rd_idx[ADDR_W-1:0];
            end
            if ((r_state == alsd_pkg::S_COUNT) && match) begin
                r_hits <= r_hits + CNT_W'(1);
            end
            if ((r_state == alsd_pkg::S_COUNT) && scan_done) begin
                r_rd_idx     <= '0;
                r_wr_idx     <= '0;
                r_emit_cnt   <= '0;
                r_fill_after <= (r_cmd == alsd_pkg::CMD_FIND_DEL) ? r_count - r_hits
                                                                  : r_count;
            end
            if (keep_wr) begin
                r_wr_idx <= r_wr_idx + CNT_W'(1);
            end
            if (emit_now) begin
                r_emit_cnt <= r_emit_cnt + CNT_W'(1);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.fill, r_out.index};
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;

    `ALSD_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(alsd_pkg::DEPTH), "fill above depth")
    `ALSD_ASSERT_IMP(a_emit_slot, emit_now, !r_out_valid, "match emitted over a waiting word")
    `ALSD_ASSERT_IMP(a_emit_bound, emit_now, r_emit_cnt < r_hits, "more matches than counted")
    `ALSD_ASSERT_IMP(a_wr_behind, keep_wr, r_wr_idx <= CNT_W'(r_cmp_idx), "write passed read")
    `ALSD_ASSERT_NXT(a_del_fill, del_done, r_count == $past(r_count - r_hits), "delete-all fill")

endmodule
